FILE: src/yuyvds_pkg.sv
// Shared types and constants of the YUYV block-average downscaler.
package yuyvds_pkg;

    localparam int LUMA_SUM_W   = 22;
    localparam int CHROMA_SUM_W = 21;
    localparam int SCALE_W      = 41;
    localparam int SCALE_LO_W   = 21;
    localparam int SCALE_HI_W   = SCALE_W - SCALE_LO_W;
    localparam int MEAN_W       = 24;
    localparam int CFG_DATA_W   = 41;
    localparam int CFG_IDX_W    = 3;

    localparam logic [MEAN_W-1:0] Q_SAT = 24'd16711680;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_WIDTH  = 3'd0,
        CFG_BLOCK_HEIGHT = 3'd1,
        CFG_OUT_WIDTH    = 3'd2,
        CFG_OUT_HEIGHT   = 3'd3,
        CFG_LUMA_SCALE   = 3'd4,
        CFG_CHROMA_SCALE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [LUMA_SUM_W-1:0]   luma;
        logic [CHROMA_SUM_W-1:0] cb;
        logic [CHROMA_SUM_W-1:0] cr;
    } t_sums;

    typedef struct packed {
        logic [7:0] col;
        logic [7:0] row;
        logic       frame_end;
    } t_meta;

endpackage

FILE: src/yuyv_block_average_downscaler.sv
// Box-filter downscaler for YUYV 4:2:2 pixel-pair streams: top level.
// Accepts one pixel pair per clock, sustained, with no gaps between frames, unless
// back-pressure from the output holds it. Per-column sums of Y, Cb and Cr live in one memory
// of MAX_OUT_WIDTH entries (one read and one write port, registered read); a back-to-back
// pair on the same column is served by forwarding the sum being written. The last pair of a
// block yields one item with the block means in unsigned Q8.16, registered in turn through
// the sum, multiply and combine stages into the output register. The memory needs no
// clearing pass: the first pair of a block overwrites.
// Configuration must be written only while the block is idle; the block does not enforce this.
module yuyv_block_average_downscaler #(
    parameter int MAX_OUT_WIDTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [yuyvds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [yuyvds_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // luma_first, chroma_blue_in, luma_second, chroma_red_in
    input  logic [31:0]                        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // luma_mean, chroma_blue_mean, chroma_red_mean, block_column, block_row
    output logic [87:0]                        m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int CW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int LW = yuyvds_pkg::LUMA_SUM_W;
    localparam int KW = yuyvds_pkg::CHROMA_SUM_W;
    localparam int SLO = yuyvds_pkg::SCALE_LO_W;
    localparam int SHI = yuyvds_pkg::SCALE_HI_W;
    localparam logic [11:0] MAX_OW = 12'(MAX_OUT_WIDTH);

    // configuration
    logic [6:0]  r_block_width;
    logic [8:0]  r_block_height;
    logic [8:0]  r_out_width;
    logic [8:0]  r_out_height;
    logic [yuyvds_pkg::SCALE_W-1:0] r_luma_scale;
    logic [yuyvds_pkg::SCALE_W-1:0] r_chroma_scale;

    // position counters
    logic [4:0]    r_pair, n_pair;
    logic [CW-1:0] r_col, n_col;
    logic [7:0]    r_line, n_line;
    logic [7:0]    r_row, n_row;

    // column sum memory
    yuyvds_pkg::t_sums r_col_sums [MAX_OUT_WIDTH];
    yuyvds_pkg::t_sums r_rd;
    yuyvds_pkg::t_sums r_fwd_sum;
    logic              r_fwd;

    // sum stage
    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_addr;
    logic              r_s1_first;
    logic              r_s1_emit;
    yuyvds_pkg::t_meta r_s1_meta;
    logic [8:0]        r_s1_y;
    logic [7:0]        r_s1_cb;
    logic [7:0]        r_s1_cr;

    // multiply stage
    logic              r_s2_valid;
    yuyvds_pkg::t_sums r_s2_sums;
    yuyvds_pkg::t_meta r_s2_meta;

    // combine stage
    logic              r_s3_valid;
    yuyvds_pkg::t_meta r_s3_meta;
    logic [LW+SLO-1:0] r_pl_lo;
    logic [LW+SHI-1:0] r_pl_hi;
    logic [KW+SLO-1:0] r_pb_lo;
    logic [KW+SHI-1:0] r_pb_hi;
    logic [KW+SLO-1:0] r_pr_lo;
    logic [KW+SHI-1:0] r_pr_hi;

    // output register
    logic                               r_out_valid;
    logic [yuyvds_pkg::MEAN_W-1:0]      r_out_luma;
    logic [yuyvds_pkg::MEAN_W-1:0]      r_out_cb;
    logic [yuyvds_pkg::MEAN_W-1:0]      r_out_cr;
    yuyvds_pkg::t_meta                  r_out_meta;

    logic [5:0]  pairs;
    logic [8:0]  bh;
    logic [8:0]  oh;
    logic [11:0] ow;
    logic [11:0] col_next;
    logic        last_pair, last_line, last_col, last_row;
    logic        first_pair, emit;
    logic        accept;
    logic        out_free, s3_adv, s2_adv, s1_adv;
    yuyvds_pkg::t_sums base, s1_sum;
    yuyvds_pkg::t_meta in_meta;

    function automatic logic [yuyvds_pkg::MEAN_W-1:0] combine_mean(
        input logic [63:0] lo,
        input logic [63:0] hi
    );
        logic [63:0] full;
        full = lo + (hi << SLO) + (64'd1 << 23);
        if (full[63:24] > 40'(yuyvds_pkg::Q_SAT)) begin
            return yuyvds_pkg::Q_SAT;
        end
        return full[47:24];
    endfunction

    // limits and position decode
    always_comb begin
        if (r_block_width[6:1] == 6'd0) begin
            pairs = 6'd1;
        end else if (r_block_width[6:1] > 6'd32) begin
            pairs = 6'd32;
        end else begin
            pairs = r_block_width[6:1];
        end
        if (r_block_height == 9'd0) begin
            bh = 9'd1;
        end else if (r_block_height > 9'd256) begin
            bh = 9'd256;
        end else begin
            bh = r_block_height;
        end
        if (r_out_height == 9'd0) begin
            oh = 9'd1;
        end else if (r_out_height > 9'd256) begin
            oh = 9'd256;
        end else begin
            oh = r_out_height;
        end
        if (r_out_width == 9'd0) begin
            ow = 12'd1;
        end else if (12'(r_out_width) > MAX_OW) begin
            ow = MAX_OW;
        end else begin
            ow = 12'(r_out_width);
        end
    end

    assign col_next   = 12'(r_col) + 12'd1;
    assign last_pair  = (6'(r_pair) + 6'd1) >= pairs;
    assign last_line  = (9'(r_line) + 9'd1) >= bh;
    assign last_col   = col_next >= ow;
    assign last_row   = (9'(r_row) + 9'd1) >= oh;
    assign first_pair = (r_pair == 5'd0) && (r_line == 8'd0);
    assign emit       = last_pair && last_line;

    always_comb begin
        in_meta.col       = col_next[7:0] - 8'd1;
        in_meta.row       = r_row;
        in_meta.frame_end = last_col && last_row;
    end

    always_comb begin
        n_pair = last_pair ? 5'd0 : r_pair + 5'd1;
        n_col  = r_col;
        n_line = r_line;
        n_row  = r_row;
        if (last_pair) begin
            n_col = last_col ? '0 : col_next[CW-1:0];
            if (last_col) begin
                n_line = last_line ? 8'd0 : r_line + 8'd1;
                if (last_line) begin
                    n_row = last_row ? 8'd0 : r_row + 8'd1;
                end
            end
        end
    end

    // handshake chain
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s3_adv        = r_s3_valid && out_free;
    assign s2_adv        = r_s2_valid && (!r_s3_valid || s3_adv);
    assign s1_adv        = r_s1_valid && (!r_s1_emit || !r_s2_valid || s2_adv);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // read-modify-write of the column sums
    always_comb begin
        base = r_fwd ? r_fwd_sum : r_rd;
        if (r_s1_first) begin
            s1_sum.luma = LW'(r_s1_y);
            s1_sum.cb   = KW'(r_s1_cb);
            s1_sum.cr   = KW'(r_s1_cr);
        end else begin
            s1_sum.luma = base.luma + LW'(r_s1_y);
            s1_sum.cb   = base.cb + KW'(r_s1_cb);
            s1_sum.cr   = base.cr + KW'(r_s1_cr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_col_sums[r_s1_addr] <= s1_sum;
        end
        if (accept) begin
            r_rd <= r_col_sums[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width  <= 7'd8;
            r_block_height <= 9'd8;
            r_out_width    <= 9'd32;
            r_out_height   <= 9'd24;
            r_luma_scale   <= '0;
            r_chroma_scale <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                yuyvds_pkg::CFG_BLOCK_WIDTH:  r_block_width  <= i_cfg_data[6:0];
                yuyvds_pkg::CFG_BLOCK_HEIGHT: r_block_height <= i_cfg_data[8:0];
                yuyvds_pkg::CFG_OUT_WIDTH:    r_out_width    <= i_cfg_data[8:0];
                yuyvds_pkg::CFG_OUT_HEIGHT:   r_out_height   <= i_cfg_data[8:0];
                yuyvds_pkg::CFG_LUMA_SCALE:   r_luma_scale   <= i_cfg_data;
                yuyvds_pkg::CFG_CHROMA_SCALE: r_chroma_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair      <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pair <= n_pair;
                r_col  <= n_col;
                r_line <= n_line;
                r_row  <= n_row;
                r_fwd  <= r_s1_valid && (r_s1_addr == r_col);
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1_emit) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_s3_valid <= 1'b1;
            end else if (s3_adv) begin
                r_s3_valid <= 1'b0;
            end
            if (s3_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_sum  <= s1_sum;
            r_s1_addr  <= r_col;
            r_s1_first <= first_pair;
            r_s1_emit  <= emit;
            r_s1_meta  <= in_meta;
            r_s1_y     <= 9'(s_axis_tdata[7:0]) + 9'(s_axis_tdata[23:16]);
            r_s1_cb    <= s_axis_tdata[15:8];
            r_s1_cr    <= s_axis_tdata[31:24];
        end
        if (s1_adv && r_s1_emit) begin
            r_s2_sums <= s1_sum;
            r_s2_meta <= r_s1_meta;
        end
        if (s2_adv) begin
            r_s3_meta <= r_s2_meta;
            r_pl_lo <= (LW+SLO)'(r_s2_sums.luma) * (LW+SLO)'(r_luma_scale[SLO-1:0]);
            r_pl_hi <= (LW+SHI)'(r_s2_sums.luma) * (LW+SHI)'(r_luma_scale[SLO+:SHI]);
            r_pb_lo <= (KW+SLO)'(r_s2_sums.cb) * (KW+SLO)'(r_chroma_scale[SLO-1:0]);
            r_pb_hi <= (KW+SHI)'(r_s2_sums.cb) * (KW+SHI)'(r_chroma_scale[SLO+:SHI]);
            r_pr_lo <= (KW+SLO)'(r_s2_sums.cr) * (KW+SLO)'(r_chroma_scale[SLO-1:0]);
            r_pr_hi <= (KW+SHI)'(r_s2_sums.cr) * (KW+SHI)'(r_chroma_scale[SLO+:SHI]);
        end
        if (s3_adv) begin
            r_out_meta <= r_s3_meta;
            r_out_luma <= combine_mean(64'(r_pl_lo), 64'(r_pl_hi));
            r_out_cb   <= combine_mean(64'(r_pb_lo), 64'(r_pb_hi));
            r_out_cr   <= combine_mean(64'(r_pr_lo), 64'(r_pr_hi));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_meta.row, r_out_meta.col, r_out_cr, r_out_cb, r_out_luma};
    assign m_axis_tlast  = r_out_meta.frame_end;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the YUYV block-average downscaler.
module tb;

    localparam int ITEM_TARGET  = 1800;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        bit [23:0] luma;
        bit [23:0] cb;
        bit [23:0] cr;
        bit [7:0]  col;
        bit [7:0]  row;
        bit        frame_end;
    } t_block_means;

    class t_block_mean_scoreboard;
        bit [6:0]  blk_w;
        bit [8:0]  blk_h;
        bit [8:0]  out_w;
        bit [8:0]  out_h;
        bit [40:0] y_scale;
        bit [40:0] c_scale;
        bit [21:0] luma_acc [256];
        bit [20:0] cb_acc [256];
        bit [20:0] cr_acc [256];
        int unsigned pair_cnt, col_cnt, line_cnt, row_cnt;
        t_block_means means_q[$];
        int unsigned errors;

        function new();
            blk_w = 7'd8;
            blk_h = 9'd8;
            out_w = 9'd32;
            out_h = 9'd24;
            y_scale = '0;
            c_scale = '0;
            pair_cnt = 0;
            col_cnt = 0;
            line_cnt = 0;
            row_cnt = 0;
            errors = 0;
        endfunction

        function int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function int unsigned pairs_per_block();
            return limit(blk_w >> 1, 1, 32);
        endfunction

        function int unsigned lines_per_block();
            return limit(blk_h, 1, 256);
        endfunction

        function int unsigned frame_pairs();
            return pairs_per_block() * lines_per_block() * limit(out_w, 1, 256)
                   * limit(out_h, 1, 256);
        endfunction

        function int unsigned block_area();
            return pairs_per_block() * 2 * lines_per_block();
        endfunction

        function void set_reg(yuyvds_pkg::t_cfg_idx idx, bit [40:0] v);
            case (idx)
                yuyvds_pkg::CFG_BLOCK_WIDTH:  blk_w = v[6:0];
                yuyvds_pkg::CFG_BLOCK_HEIGHT: blk_h = v[8:0];
                yuyvds_pkg::CFG_OUT_WIDTH:    out_w = v[8:0];
                yuyvds_pkg::CFG_OUT_HEIGHT:   out_h = v[8:0];
                yuyvds_pkg::CFG_LUMA_SCALE:   y_scale = v;
                yuyvds_pkg::CFG_CHROMA_SCALE: c_scale = v;
                default: ;
            endcase
        endfunction

        function bit [23:0] to_q8_16(bit [21:0] sum, bit [40:0] k);
            bit [63:0] p;
            p = (64'(sum) * 64'(k) + (64'd1 << 23)) >> 24;
            return (p > 64'(yuyvds_pkg::Q_SAT)) ? yuyvds_pkg::Q_SAT : p[23:0];
        endfunction

        function void note_pair(bit [31:0] d);
            int unsigned pairs, bh, ow, oh;
            t_block_means r;
            pairs = pairs_per_block();
            bh = lines_per_block();
            ow = limit(out_w, 1, 256);
            oh = limit(out_h, 1, 256);
            if (pair_cnt == 0 && line_cnt == 0) begin
                luma_acc[col_cnt] = 22'(d[7:0]) + 22'(d[23:16]);
                cb_acc[col_cnt] = 21'(d[15:8]);
                cr_acc[col_cnt] = 21'(d[31:24]);
            end else begin
                luma_acc[col_cnt] += 22'(d[7:0]) + 22'(d[23:16]);
                cb_acc[col_cnt] += 21'(d[15:8]);
                cr_acc[col_cnt] += 21'(d[31:24]);
            end
            if (pair_cnt + 1 >= pairs && line_cnt + 1 >= bh) begin
                r.luma = to_q8_16(luma_acc[col_cnt], y_scale);
                r.cb = to_q8_16(22'(cb_acc[col_cnt]), c_scale);
                r.cr = to_q8_16(22'(cr_acc[col_cnt]), c_scale);
                r.col = col_cnt[7:0];
                r.row = row_cnt[7:0];
                r.frame_end = (col_cnt + 1 >= ow && row_cnt + 1 >= oh);
                means_q.push_back(r);
            end
            pair_cnt++;
            if (pair_cnt >= pairs) begin
                pair_cnt = 0;
                col_cnt++;
                if (col_cnt >= ow) begin
                    col_cnt = 0;
                    line_cnt++;
                    if (line_cnt >= bh) begin
                        line_cnt = 0;
                        row_cnt++;
                        if (row_cnt >= oh)
                            row_cnt = 0;
                    end
                end
            end
        endfunction

        function int unsigned pending();
            return means_q.size();
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            if (errors < 100)
                $display("MISMATCH %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_block(bit [87:0] data, bit last);
            t_block_means w;
            if (means_q.size() == 0) begin
                report("unexpected item", data[63:0], 0);
                return;
            end
            w = means_q.pop_front();
            if (data[23:0] != w.luma) report("luma_mean", data[23:0], w.luma);
            if (data[47:24] != w.cb) report("chroma_blue_mean", data[47:24], w.cb);
            if (data[71:48] != w.cr) report("chroma_red_mean", data[71:48], w.cr);
            if (data[79:72] != w.col) report("block_column", data[79:72], w.col);
            if (data[87:80] != w.row) report("block_row", data[87:80], w.row);
            if (last != w.frame_end) report("frame_end", last, w.frame_end);
        endtask

        task flush_check();
            while (means_q.size() != 0) begin
                report("missing item", 0, means_q[0].col);
                void'(means_q.pop_front());
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [yuyvds_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [yuyvds_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_block_mean_scoreboard sb = new();
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_started = 1'b0;
    int unsigned hold_left = 0;
    int unsigned pairs_sent = 0;
    int unsigned quiet_cycles = 0;

    yuyv_block_average_downscaler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // receiver: random stalls plus a single long hold-off
    always @(posedge i_clk) begin
        if (hold_go && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_block(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("yuyv_block_average_downscaler regression: fail");
                $finish;
            end
        end
    end

    // write enable stays high across a burst of writes; write_scales ends the burst
    task automatic write_reg(input yuyvds_pkg::t_cfg_idx idx, input bit [40:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_geometry(input bit [6:0] bw, input bit [8:0] bh,
                                  input bit [8:0] ow, input bit [8:0] oh);
        write_reg(yuyvds_pkg::CFG_BLOCK_WIDTH, 41'(bw));
        write_reg(yuyvds_pkg::CFG_BLOCK_HEIGHT, 41'(bh));
        write_reg(yuyvds_pkg::CFG_OUT_WIDTH, 41'(ow));
        write_reg(yuyvds_pkg::CFG_OUT_HEIGHT, 41'(oh));
    endtask

    task automatic write_scales(input bit [40:0] ys, input bit [40:0] cs);
        write_reg(yuyvds_pkg::CFG_LUMA_SCALE, ys);
        write_reg(yuyvds_pkg::CFG_CHROMA_SCALE, cs);
        i_cfg_we <= 1'b0;
    endtask

    // raw, normalized, random, saturating or zero reciprocals
    task automatic pick_scales();
        bit [40:0] area;
        area = 41'(sb.block_area());
        case ($urandom_range(5))
            0, 1: write_scales((41'd1 << 40) / area, (41'd1 << 40) / area * 2);
            2: write_scales((41'd1 << 40) / (area * 255), (41'd1 << 40) / (area * 255) * 2);
            3: write_scales(41'({$urandom, $urandom}), 41'({$urandom, $urandom}));
            4: write_scales({41{1'b1}}, 41'd1 << 40);
            default: write_scales('0, 41'($urandom));
        endcase
    endtask

    task automatic push_pair(input bit [31:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_pair(d);
        pairs_sent++;
    endtask

    function automatic bit [31:0] random_pair();
        bit [31:0] d;
        d = $urandom;
        if ($urandom_range(9) == 0) begin
            for (int b = 0; b < 4; b++)
                d[8*b +: 8] = $urandom_range(1) ? 8'hff : 8'h00;
        end
        return d;
    endfunction

    task automatic send_frames(input int unsigned frames);
        int unsigned total;
        total = frames * sb.frame_pairs();
        for (int unsigned n = 0; n < total; n++)
            push_pair(random_pair());
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_geometry();
        bit [6:0] bw;
        bit [8:0] bh, ow, oh;
        int unsigned pairs, budget, r;
        r = $urandom_range(9);
        if (r < 7)
            bw = 7'd4 << $urandom_range(2);
        else if (r == 7)
            bw = 7'(8 * $urandom_range(1, 8));
        else
            bw = 7'($urandom_range(127));
        pairs = sb.limit(bw >> 1, 1, 32);
        budget = 192 / pairs;
        bh = 9'($urandom_range(1, sb.limit(budget, 1, 8)));
        budget = budget / bh;
        ow = 9'($urandom_range(1, sb.limit(budget, 1, 16)));
        budget = budget / ow;
        oh = 9'($urandom_range(1, sb.limit(budget, 1, 8)));
        if (bh == 1 && $urandom_range(3) == 0) bh = 0;
        if (ow == 1 && $urandom_range(3) == 0) ow = 0;
        if (oh == 1 && $urandom_range(3) == 0) oh = 0;
        write_geometry(bw, bh, ow, oh);
    endtask

    initial begin
        int unsigned phase;
        int unsigned frames;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two-pair blocks on a 2x2 grid, raw scale
        write_geometry(7'd4, 9'd1, 9'd2, 9'd2);
        write_scales(41'd1 << 38, 41'd1 << 39);
        push_pair(32'h0000_0000);
        push_pair(32'hffff_ffff);
        push_pair(32'h00ff_00ff);
        push_pair(32'hff00_ff00);
        push_pair(32'h55aa_55aa);
        push_pair(32'haa55_aa55);
        push_pair(32'h0180_0180);
        push_pair(32'h8001_8001);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // zero sizes clamp to one pair per frame; full-scale factors saturate
        write_geometry(7'd0, 9'd0, 9'd0, 9'd0);
        write_scales({41{1'b1}}, {41{1'b1}});
        push_pair(32'hffff_ffff);
        push_pair(32'h0000_0000);
        push_pair(32'h0101_0101);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // odd block width drops a pixel, normalized scale
        write_geometry(7'd7, 9'd2, 9'd1, 9'd1);
        write_scales((41'd1 << 40) / (41'd12 * 255), (41'd1 << 40) / (41'd12 * 255) * 2);
        push_pair(32'hffff_ffff);
        push_pair(32'h0000_0000);
        push_pair(32'h12ff_34ff);
        push_pair(32'hff00_ff00);
        push_pair(32'h7f80_7f80);
        push_pair(32'hffff_ffff);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // rounding half up
        write_geometry(7'd2, 9'd1, 9'd1, 9'd1);
        write_scales(41'd1 << 23, 41'd1 << 23);
        push_pair(32'h0100_0101);
        push_pair(32'h0301_0003);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        phase = 0;
        while (pairs_sent < ITEM_TARGET) begin
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
                default: begin src_idle_pct = 34; snk_stall_pct = 34; end
            endcase
            case (phase)
                0: write_geometry(7'd127, 9'd1, 9'd1, 9'd1);
                1: write_geometry(7'd2, 9'd511, 9'd1, 9'd1);
                2: write_geometry(7'd1, 9'd1, 9'd511, 9'd1);
                3: write_geometry(7'd0, 9'd256, 9'd1, 9'd0);
                4: write_geometry(7'd0, 9'd0, 9'd1, 9'd511);
                5: write_geometry(7'd64, 9'd8, 9'd1, 9'd1);
                6: write_geometry(7'd2, 9'd1, 9'd8, 9'd8);
                default: random_geometry();
            endcase
            pick_scales();
            if (phase == 6) begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
                hold_go = 1'b1;
            end
            frames = 160 / sb.frame_pairs();
            send_frames(frames == 0 ? 1 : frames);
            wait_drained();
            phase++;
        end

        sb.flush_check();
        if (sb.errors == 0)
            $display("yuyv_block_average_downscaler regression: pass");
        else
            $display("yuyv_block_average_downscaler regression: fail");
        $finish;
    end
endmodule
